// ===== rtl/itp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_TERM   = 8'h00;

	localparam logic [2:0] PREC_NONE   = 3'd0;
	localparam logic [2:0] PREC_RPAREN = 3'd1;
	localparam logic [2:0] PREC_ADD    = 3'd2;
	localparam logic [2:0] PREC_MUL    = 3'd3;
	localparam logic [2:0] PREC_POW    = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_REFILL,
		ST_POST,
		ST_FLUSH,
		ST_FLUSH_WAIT,
		ST_TERM,
		ST_CLOSE
	} itp_state_t;

	// request from the sequencer to the output stage
	typedef struct packed {
		logic       valid;
		logic       close;
		logic [7:0] chr;
		logic       done;
		logic       err;
	} itp_emit_t;

	typedef struct packed {
		logic emit_ok;
		logic close_ok;
	} itp_ostat_t;

	function automatic logic [2:0] prec_of(input logic [7:0] c);
		logic [2:0] p;
		case (c)
			CH_PLUS, CH_MINUS: p = PREC_ADD;
			CH_STAR, CH_SLASH: p = PREC_MUL;
			CH_CARET:          p = PREC_POW;
			CH_RPAREN:         p = PREC_RPAREN;
			default:           p = PREC_NONE;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/itp_stack_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module itp_stack_ram (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [itp_pkg::ADDR_W-1:0] waddr,
	input  wire logic [7:0]                wdata,
	input  wire logic [itp_pkg::ADDR_W-1:0] raddr,
	output logic      [7:0]                rdata
);

	logic [7:0] mem [itp_pkg::STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/itp_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module itp_out_stage (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire itp_pkg::itp_emit_t   emit,
	output itp_pkg::itp_ostat_t       ostat,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [7:0]                out_char,
	output logic                      last_of_run,
	output logic                      expr_done,
	output logic                      error
);

	logic       pend_valid_q;
	logic [7:0] pend_char_q;
	logic       pend_done_q;
	logic       pend_err_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       out_last_q;
	logic       out_done_q;
	logic       out_err_q;
	logic       out_free;
	logic       load_out;
	logic       drain;

	// one item is held back until it is known whether another follows it
	assign out_free       = !out_valid_q || out_ready;
	assign ostat.emit_ok  = !pend_valid_q || out_free;
	assign ostat.close_ok = !pend_valid_q || out_free;
	assign drain          = emit.close && pend_valid_q && out_free;
	assign load_out       = (emit.valid && pend_valid_q) || drain;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit.valid) begin
				pend_valid_q <= 1'b1;
			end else if (drain) begin
				pend_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			pend_char_q <= emit.chr;
			pend_done_q <= emit.done;
			pend_err_q  <= emit.err;
		end
		if (load_out) begin
			out_char_q <= pend_char_q;
			out_done_q <= pend_done_q;
			out_err_q  <= pend_err_q;
			out_last_q <= drain;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign last_of_run = out_last_q;
	assign expr_done   = out_done_q;
	assign error       = out_err_q;

endmodule

`default_nettype wire

// ===== rtl/itp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module itp_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [7:0]                 symbol,
	input  wire logic                       end_of_expr,
	output logic                            ram_we,
	output logic [itp_pkg::ADDR_W-1:0]      ram_waddr,
	output logic [7:0]                      ram_wdata,
	output logic [itp_pkg::ADDR_W-1:0]      ram_raddr,
	input  wire logic [7:0]                 ram_rdata,
	output itp_pkg::itp_emit_t              emit,
	input  wire itp_pkg::itp_ostat_t        ostat
);

	itp_pkg::itp_state_t state_q, state_d;

	logic [7:0]              sym_q;
	logic                    end_q;
	logic [itp_pkg::CNT_W-1:0] cnt_q;
	logic                    err_q;

	logic       cnt_zero;
	logic       full;
	logic       is_rp;
	logic       is_lp;
	logic       is_op;
	logic [2:0] sym_p;
	logic [2:0] top_p;
	logic       pop_op;
	logic       top_is_rp;

	logic push;
	logic pop;
	logic set_err;

	always_comb begin
		cnt_zero  = (cnt_q == '0);
		full      = (cnt_q == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
		is_rp     = (sym_q == itp_pkg::CH_RPAREN);
		is_lp     = (sym_q == itp_pkg::CH_LPAREN);
		sym_p     = itp_pkg::prec_of(sym_q);
		is_op     = (sym_p >= itp_pkg::PREC_ADD);
		// empty stack acts like a ')' on top
		top_p     = cnt_zero ? itp_pkg::PREC_RPAREN : itp_pkg::prec_of(ram_rdata);
		// '^' is right associative in the reversed scan
		pop_op    = (top_p > sym_p) || ((top_p == sym_p) && (sym_q == itp_pkg::CH_CARET));
		top_is_rp = (ram_rdata == itp_pkg::CH_RPAREN);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			itp_pkg::ST_IDLE: begin
				if (in_valid) state_d = itp_pkg::ST_EVAL;
			end
			itp_pkg::ST_EVAL: begin
				if (is_rp) begin
					state_d = itp_pkg::ST_POST;
				end else if (is_lp) begin
					if (cnt_zero || top_is_rp) state_d = itp_pkg::ST_POST;
					else if (ostat.emit_ok)    state_d = itp_pkg::ST_REFILL;
				end else if (is_op) begin
					if (!pop_op)             state_d = itp_pkg::ST_POST;
					else if (ostat.emit_ok)  state_d = itp_pkg::ST_REFILL;
				end else if (ostat.emit_ok) begin
					state_d = itp_pkg::ST_POST;
				end
			end
			itp_pkg::ST_REFILL: state_d = itp_pkg::ST_EVAL;
			itp_pkg::ST_POST: begin
				state_d = end_q ? itp_pkg::ST_FLUSH : itp_pkg::ST_CLOSE;
			end
			itp_pkg::ST_FLUSH: begin
				if (cnt_zero)                         state_d = itp_pkg::ST_TERM;
				else if (top_is_rp || ostat.emit_ok)  state_d = itp_pkg::ST_FLUSH_WAIT;
			end
			itp_pkg::ST_FLUSH_WAIT: state_d = itp_pkg::ST_FLUSH;
			itp_pkg::ST_TERM: begin
				if (ostat.emit_ok) state_d = itp_pkg::ST_CLOSE;
			end
			itp_pkg::ST_CLOSE: begin
				if (ostat.close_ok) state_d = itp_pkg::ST_IDLE;
			end
			default: state_d = itp_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready   = 1'b0;
		push       = 1'b0;
		pop        = 1'b0;
		set_err    = 1'b0;
		emit.valid = 1'b0;
		emit.close = 1'b0;
		emit.chr   = ram_rdata;
		emit.done  = 1'b0;
		emit.err   = err_q;
		case (state_q)
			itp_pkg::ST_IDLE: in_ready = 1'b1;
			itp_pkg::ST_EVAL: begin
				if (is_rp) begin
					push = 1'b1;
				end else if (is_lp) begin
					if (cnt_zero) begin
						set_err = 1'b1;
					end else if (top_is_rp) begin
						pop = 1'b1;
					end else begin
						emit.valid = ostat.emit_ok;
						pop        = ostat.emit_ok;
					end
				end else if (is_op) begin
					if (pop_op) begin
						emit.valid = ostat.emit_ok;
						pop        = ostat.emit_ok;
					end else begin
						push = 1'b1;
					end
				end else begin
					emit.valid = ostat.emit_ok;
					emit.chr   = sym_q;
				end
			end
			itp_pkg::ST_FLUSH: begin
				if (!cnt_zero) begin
					if (top_is_rp) begin
						pop     = 1'b1;
						set_err = 1'b1;
					end else begin
						emit.valid = ostat.emit_ok;
						pop        = ostat.emit_ok;
					end
				end
			end
			itp_pkg::ST_TERM: begin
				emit.valid = ostat.emit_ok;
				emit.chr   = itp_pkg::CH_TERM;
				emit.done  = 1'b1;
			end
			itp_pkg::ST_CLOSE: emit.close = 1'b1;
			default: ;
		endcase
	end

	assign ram_we    = push && !full;
	assign ram_waddr = cnt_q[itp_pkg::ADDR_W-1:0];
	assign ram_wdata = sym_q;
	// the ram always looks at the current top; a new top shows in the cycle after cnt_q moves
	assign ram_raddr = itp_pkg::ADDR_W'(cnt_q - itp_pkg::CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itp_pkg::ST_IDLE;
			cnt_q   <= '0;
			err_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push && !full) begin
				cnt_q <= cnt_q + itp_pkg::CNT_W'(1);
			end else if (pop) begin
				cnt_q <= cnt_q - itp_pkg::CNT_W'(1);
			end
			if (set_err || (push && full)) begin
				err_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sym_q <= symbol;
			end_q <= end_of_expr;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/infix_to_prefix_operator_stack.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   signals                                      direction
// input     in_valid, in_ready, symbol, end_of_expr      in
// output    out_valid, out_ready, out_char, last_of_run,  out
//           expr_done, error
//
// one item at a time: an operand or a push passes idle, eval, post and close; each popped
// operator adds a pop and a refill step (the stack ram's registered read of the new top),
// and an end flag adds a flush and a terminator step plus a flush and a wait per entry
// reset clears the stack count, the sticky error and the valid flags of both output registers at once
// a stalled output holds the sequencer only when a new result finds the held one and
// the output register both occupied

module infix_to_prefix_operator_stack (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] symbol,
	input  wire logic       end_of_expr,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_char,
	output logic            last_of_run,
	output logic            expr_done,
	output logic            error
);

	logic                        ram_we;
	logic [itp_pkg::ADDR_W-1:0]  ram_waddr;
	logic [7:0]                  ram_wdata;
	logic [itp_pkg::ADDR_W-1:0]  ram_raddr;
	logic [7:0]                  ram_rdata;
	itp_pkg::itp_emit_t          emit;
	itp_pkg::itp_ostat_t         ostat;

	itp_stack_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	itp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.symbol      (symbol),
		.end_of_expr (end_of_expr),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata),
		.emit        (emit),
		.ostat       (ostat)
	);

	itp_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.emit        (emit),
		.ostat       (ostat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.last_of_run (last_of_run),
		.expr_done   (expr_done),
		.error       (error)
	);

endmodule

`default_nettype wire
